>>> hdl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and codes of the byte ring buffer: operation kinds, result
// status codes, field widths and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package brb_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 9;
    localparam int SIZE_W   = 9;

    // Stream word widths
    localparam int S_TDATA_W = 16;  // count, data_byte
    localparam int M_TDATA_W = 24;  // out_byte, level
    localparam int M_TUSER_W = 3;   // has_byte, status

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                has_byte;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [LEVEL_W-1:0]  level;
    } brb_result_t;

endpackage

>>> hdl/byte_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_core
// Byte ring buffer with write, read, peek and flush; usable size set by a
// register of at most DEPTH slots.
//
//   Channel   Direction  Transaction
//   s_axis    in         one item: kind in tuser, data_byte/count in tdata
//   m_axis    out        one result: has_byte/status in tuser, tlast = last
//   cfg       in         buffer_size write, also empties the buffer
//
// Write, flush, error and empty-count items each produce a single result.
// A read or peek run of n bytes first fetches one byte through the storage
// read port, then delivers one byte per cycle from that port unless m_axis stalls.
// The next item is taken once the final byte enters the output register.
// Reset clears positions and level and sets size to 256; storage is not cleared.
// A stalled m_axis holds the output register and pauses the run.
// ----------------------------------------------------------------------------
module byte_ring_buffer_core #(
    parameter int DEPTH   = 256,
    parameter int MAX_RUN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic [brb_pkg::SIZE_W-1:0]    cfg_wr_data,
    // Item stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [brb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // data_byte[7:0], count[14:8]
    input  logic [brb_pkg::KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [brb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte[7:0], level[16:8]
    output logic [brb_pkg::M_TUSER_W-1:0] m_axis_tuser,  // has_byte[0], status[2:1]
    output logic                          m_axis_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       res_valid;
    logic                       res_ready;
    brb_pkg::brb_result_t       res;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [brb_pkg::BYTE_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [brb_pkg::BYTE_W-1:0] mem_rd_data;

    logic                       out_valid_reg, out_valid_next;
    brb_pkg::brb_result_t       out_res_reg;

    brb_ctrl #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN),
        .AW      (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .kind        (s_axis_tuser),
        .data_byte   (s_axis_tdata[7:0]),
        .count       (s_axis_tdata[14:8]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    brb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload on each transaction into the register
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.level, out_res_reg.out_byte};
    assign m_axis_tuser  = {out_res_reg.status, out_res_reg.has_byte};
    assign m_axis_tlast  = out_res_reg.last;

endmodule

>>> hdl/brb_store.sv
// ----------------------------------------------------------------------------
// brb_store
// Byte storage: one write port and one read port, read data registered and
// held between read strobes.
// ----------------------------------------------------------------------------
module brb_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [brb_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [brb_pkg::BYTE_W-1:0] rd_data
);

    logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [brb_pkg::BYTE_W-1:0] rd_data_reg;

    // Store one byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Fetch one byte, hold it until the next fetch
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Ring buffer sequencer: keeps positions, fill level and size, decodes each
// item, writes bytes into storage and steps through read and peek runs one
// byte per cycle while the result side is not stalled.
// ----------------------------------------------------------------------------
module brb_ctrl #(
    parameter int DEPTH   = 256,
    parameter int MAX_RUN = 64,
    parameter int AW      = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration
    input  logic                        cfg_wr_en,
    input  logic [brb_pkg::SIZE_W-1:0]  cfg_wr_data,
    // Item in
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [brb_pkg::KIND_W-1:0]  kind,
    input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [brb_pkg::COUNT_W-1:0] count,
    // Result out
    output logic                        res_valid,
    input  logic                        res_ready,
    output brb_pkg::brb_result_t        res,
    // Storage port
    output logic                        mem_wr_en,
    output logic [AW-1:0]               mem_wr_addr,
    output logic [brb_pkg::BYTE_W-1:0]  mem_wr_data,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_rd_addr,
    input  logic [brb_pkg::BYTE_W-1:0]  mem_rd_data
);

    localparam int SW = brb_pkg::SIZE_W;
    localparam int CW = (AW + 1 > SW) ? AW + 1 : SW;
    localparam int CAP = (DEPTH > 511) ? 511 : DEPTH;
    localparam logic [SW-1:0] SIZE_CAP = SW'(CAP);
    localparam logic [brb_pkg::COUNT_W-1:0] RUN_MAX = brb_pkg::COUNT_W'(MAX_RUN);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                        state_reg, state_next;
    logic [SW-1:0]               size_reg, size_next;
    logic [AW-1:0]               rpos_reg, rpos_next;
    logic [AW-1:0]               wpos_reg, wpos_next;
    logic [SW-1:0]               fill_reg, fill_next;
    logic [AW-1:0]               run_pos_reg, run_pos_next;
    logic [brb_pkg::COUNT_W-1:0] issue_left_reg, issue_left_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic                        pend_last_reg, pend_last_next;

    logic [SW-1:0]               size_used;
    logic [SW-1:0]               count_ext;
    logic                        is_full;
    logic                        is_run_kind;
    logic                        bad_count;
    logic                        start_run;
    logic                        accept;
    logic                        issue;
    logic                        pop;
    logic [CW-1:0]               run_inc_w;
    logic [AW-1:0]               run_pos_inc;
    logic [CW-1:0]               wpos_inc_w;
    logic [AW-1:0]               wpos_inc;
    logic [CW-1:0]               rpos_sum;
    logic [AW-1:0]               rpos_adv;

    // Clamp the size register into 1..min(DEPTH, 511)
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_used = SW'(1);
        end
        else if (size_reg > SIZE_CAP)
        begin
            size_used = SIZE_CAP;
        end
        else
        begin
            size_used = size_reg;
        end
    end

    // Decode the item
    assign count_ext   = SW'(count);
    assign is_full     = fill_reg >= size_used;
    assign is_run_kind = (kind == brb_pkg::KIND_READ) || (kind == brb_pkg::KIND_PEEK);
    assign bad_count   = (count_ext > fill_reg) || (count > RUN_MAX);
    assign start_run   = is_run_kind && !bad_count && (count != '0);

    // Handshakes
    assign in_ready  = (state_reg == ST_IDLE) && res_ready;
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_IDLE) ? (in_valid && !start_run) : pend_valid_reg;
    assign pop       = (state_reg == ST_RUN) && pend_valid_reg && res_ready;
    assign issue     = (state_reg == ST_RUN) && (issue_left_reg != '0)
                       && (!pend_valid_reg || pop);

    // Position arithmetic, wrapping at the used size
    assign run_inc_w   = CW'(run_pos_reg) + CW'(1);
    assign run_pos_inc = (run_inc_w == CW'(size_used)) ? '0 : AW'(run_inc_w);
    assign wpos_inc_w  = CW'(wpos_reg) + CW'(1);
    assign wpos_inc    = (wpos_inc_w == CW'(size_used)) ? '0 : AW'(wpos_inc_w);
    assign rpos_sum    = CW'(rpos_reg) + CW'(count);
    assign rpos_adv    = (rpos_sum >= CW'(size_used)) ? AW'(rpos_sum - CW'(size_used))
                                                      : AW'(rpos_sum);

    // Storage access
    assign mem_wr_en   = accept && (kind == brb_pkg::KIND_WRITE) && !is_full;
    assign mem_wr_addr = wpos_reg;
    assign mem_wr_data = data_byte;
    assign mem_rd_en   = issue;
    assign mem_rd_addr = run_pos_reg;

    // Next state
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        rpos_next       = rpos_reg;
        wpos_next       = wpos_reg;
        fill_next       = fill_reg;
        run_pos_next    = run_pos_reg;
        issue_left_next = issue_left_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                priority if (cfg_wr_en)
                begin
                    // New size empties the buffer
                    size_next = cfg_wr_data;
                    rpos_next = '0;
                    wpos_next = '0;
                    fill_next = '0;
                end
                else if (accept)
                begin
                    unique case (kind)
                        brb_pkg::KIND_WRITE:
                        begin
                            if (!is_full)
                            begin
                                wpos_next = wpos_inc;
                                fill_next = fill_reg + SW'(1);
                            end
                        end
                        brb_pkg::KIND_FLUSH:
                        begin
                            rpos_next = '0;
                            wpos_next = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                            if (start_run)
                            begin
                                state_next      = ST_RUN;
                                run_pos_next    = rpos_reg;
                                issue_left_next = count;
                                pend_valid_next = 1'b0;
                                if (kind == brb_pkg::KIND_READ)
                                begin
                                    fill_next = fill_reg - count_ext;
                                    rpos_next = rpos_adv;
                                end
                            end
                        end
                    endcase
                end
                else
                begin
                    // Hold while no transaction arrives
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                // Fetch the next byte when the pending slot frees up
                if (issue)
                begin
                    run_pos_next    = run_pos_inc;
                    issue_left_next = issue_left_reg - brb_pkg::COUNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_last_next  = (issue_left_reg == brb_pkg::COUNT_W'(1));
                end
                else if (pop)
                begin
                    pend_valid_next = 1'b0;
                end
                // Leave the run once the final byte is handed over
                if (pop && pend_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Result record
    always_comb
    begin
        res.out_byte = '0;
        res.has_byte = 1'b0;
        res.status   = brb_pkg::STATUS_OK;
        res.last     = 1'b1;
        res.level    = fill_reg;
        if (state_reg == ST_RUN)
        begin
            res.out_byte = mem_rd_data;
            res.has_byte = 1'b1;
            res.last     = pend_last_reg;
        end
        else
        begin
            unique case (kind)
                brb_pkg::KIND_WRITE:
                begin
                    if (is_full)
                    begin
                        res.status = brb_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        res.level = fill_reg + SW'(1);
                    end
                end
                brb_pkg::KIND_FLUSH:
                begin
                    res.level = '0;
                end
                default:
                begin
                    if (bad_count)
                    begin
                        res.status = brb_pkg::STATUS_RANGE;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= SW'(256);
            rpos_reg       <= '0;
            wpos_reg       <= '0;
            fill_reg       <= '0;
            run_pos_reg    <= '0;
            issue_left_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            rpos_reg       <= rpos_next;
            wpos_reg       <= wpos_next;
            fill_reg       <= fill_next;
            run_pos_reg    <= run_pos_next;
            issue_left_reg <= issue_left_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
        end
    end

endmodule
